// ===== hw/rtl/stereo_feedback_delay_top_assert.svh =====
// ----------------------------------------------------------------------------
// stereo_feedback_delay_top_assert.svh
// Assertion macros shared by the stereo feedback delay modules.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_TOP_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define SFD_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, register indexes and constants of the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Q1.15 unity
    localparam logic [GAIN_W-1:0] Q_ONE = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd3;

    localparam logic [GAIN_W-1:0]  RST_OUT_GAIN      = 16'd32768;
    localparam logic [GAIN_W-1:0]  RST_FEEDBACK_GAIN = 16'd11469;
    localparam logic [GAIN_W-1:0]  RST_WET_MIX       = 16'd16384;
    localparam logic [DELAY_W-1:0] RST_DELAY_SAMPLES = 17'd39322;

    // Gains as seen by the datapath, already limited to unity
    typedef struct packed {
        logic [GAIN_W-1:0] out_gain;
        logic [GAIN_W-1:0] feedback_gain;
        logic [GAIN_W-1:0] wet_mix;
    } t_cfg;

    function automatic logic [GAIN_W-1:0] clamp_q(input logic [GAIN_W-1:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

endpackage

// ===== hw/rtl/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_queue
// Two-entry register queue between the front and back parts.
// ----------------------------------------------------------------------------
module sfd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam int ENTRIES = 2;

    logic [WIDTH-1:0] r_data [ENTRIES];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_data[r_wr_ptr] <= i_push_data;
                r_wr_ptr         <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_head  = r_data[r_rd_ptr];
    assign o_full  = (r_count == 2'(ENTRIES));
    assign o_empty = (r_count == 2'd0);

endmodule

// ===== hw/rtl/sfd_front.sv =====
// ----------------------------------------------------------------------------
// sfd_front
// Accepts items, holds configuration and write pointers, and forms the
// read and write addresses of each item before queuing it.
// ----------------------------------------------------------------------------
`include "stereo_feedback_delay_top_assert.svh"

module sfd_front #(
    parameter  int DEPTH    = 131072,
    parameter  int CHANNELS = 2,
    localparam int AW       = $clog2(DEPTH),
    localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int QW       = CW + 2 * AW + 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_channel,
    input  logic signed [23:0]           i_sample_in,
    input  logic                         i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sfd_pkg::t_cfg                o_cfg,
    input  logic                         i_clearing,
    input  logic                         i_q_full,
    output logic                         o_push,
    output logic [QW-1:0]                o_push_data
);

    import sfd_pkg::*;

    localparam int MW  = DELAY_W + AW;
    localparam int RS  = DELAY_W + AW;
    localparam int RMW = DELAY_W + 2;
    localparam int PW  = DELAY_W + RMW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RS) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [RMW-1:0] RECIP = RMW'(RECIP_L);

    t_cfg               r_cfg;
    logic [DELAY_W-1:0] r_dmod;
    logic               r_mod_busy;
    logic               r_mod_ph;
    logic [DELAY_W-1:0] r_quot;
    logic [AW-1:0]      r_wp [CHANNELS];

    logic [CW-1:0]      w_ch;
    logic [AW-1:0]      w_wp;
    logic [AW-1:0]      w_wp_inc;
    logic [AW-1:0]      w_d;
    logic [AW:0]        w_diff;
    logic [AW-1:0]      w_rp;
    logic [PW-1:0]      w_rprod;
    logic [DELAY_W-1:0] w_quot;
    logic [DELAY_W-1:0] w_qd;
    logic               w_accept;

    // A channel beyond the configured count folds back to zero
    assign w_ch     = (CHANNELS > 1) ? CW'(i_channel) : '0;
    assign w_wp     = r_wp[w_ch];
    assign w_wp_inc = (w_wp == AW'(DEPTH - 1)) ? '0 : w_wp + 1'b1;
    assign w_d      = AW'(r_dmod);
    assign w_diff   = {1'b0, w_wp} - {1'b0, w_d};
    assign w_rp     = w_diff[AW] ? AW'(w_diff + (AW + 1)'(DEPTH)) : w_diff[AW-1:0];

    // Delay modulo DEPTH: quotient by reciprocal multiply, then subtract
    assign w_rprod = PW'(r_dmod) * PW'(RECIP);
    assign w_quot  = DELAY_W'(w_rprod >> RS);
    assign w_qd    = r_quot * DELAY_W'(DEPTH);

    assign o_in_stall  = i_q_full | i_clearing | r_mod_busy;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_push      = w_accept;
    assign o_push_data = {w_ch, w_wp, w_rp, i_sample_in};
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_gain      <= RST_OUT_GAIN;
            r_cfg.feedback_gain <= RST_FEEDBACK_GAIN;
            r_cfg.wet_mix       <= RST_WET_MIX;
            r_dmod              <= RST_DELAY_SAMPLES;
            r_mod_busy          <= 1'b1;
            r_mod_ph            <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OUT_GAIN: begin
                    r_cfg.out_gain <= clamp_q(i_cfg_data[GAIN_W-1:0]);
                end
                REG_FEEDBACK_GAIN: begin
                    r_cfg.feedback_gain <= clamp_q(i_cfg_data[GAIN_W-1:0]);
                end
                REG_WET_MIX: begin
                    r_cfg.wet_mix <= clamp_q(i_cfg_data[GAIN_W-1:0]);
                end
                REG_DELAY_SAMPLES: begin
                    r_dmod     <= i_cfg_data[DELAY_W-1:0];
                    r_mod_busy <= 1'b1;
                    r_mod_ph   <= 1'b0;
                end
                default: begin
                end
            endcase
        end else if (r_mod_busy) begin
            if (!r_mod_ph) begin
                r_quot   <= w_quot;
                r_mod_ph <= 1'b1;
            end else begin
                r_dmod     <= r_dmod - w_qd;
                r_mod_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i] <= '0;
            end
        end else if (w_accept) begin
            r_wp[w_ch] <= w_wp_inc;
        end
    end

    `SFD_ASSERT(a_no_accept_busy, o_push, !r_mod_busy && !i_clearing && !i_q_full, "accept while busy")
    `SFD_ASSERT_NEXT(a_delay_write_reduces, i_cfg_we && (i_cfg_index == REG_DELAY_SAMPLES), r_mod_busy, "delay write did not start reduction")
    `SFD_ASSERT(a_delay_in_range, !r_mod_busy, MW'(r_dmod) < MW'(DEPTH), "reduced delay not below depth")

endmodule

// ===== hw/rtl/sfd_back.sv =====
// ----------------------------------------------------------------------------
// sfd_back
// Carries out queued items: delay memory read, feedback write-back,
// dry/wet mix and output gain; also runs the memory clearing pass.
// ----------------------------------------------------------------------------
`include "stereo_feedback_delay_top_assert.svh"

module sfd_back #(
    parameter  int DEPTH    = 131072,
    parameter  int CHANNELS = 2,
    localparam int AW       = $clog2(DEPTH),
    localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int QW       = CW + 2 * AW + 24,
    localparam int RAW      = CW + AW,
    localparam int NW       = CHANNELS * (2 ** AW)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfd_pkg::t_cfg      i_cfg,
    input  logic               i_q_empty,
    input  logic [QW-1:0]      i_q_data,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_ram_we,
    output logic [RAW-1:0]     o_ram_waddr,
    output logic [23:0]        o_ram_wdata,
    output logic [RAW-1:0]     o_ram_raddr,
    input  logic [23:0]        i_ram_rdata,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_sample_out
);

    import sfd_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_WT, S_WB, S_MX, S_GN1, S_GN2, S_OUT
    } t_state;

    t_state             r_state;
    logic [RAW-1:0]     r_clr_addr;
    logic [CW-1:0]      r_ch;
    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_rp;
    logic signed [23:0] r_x;
    logic signed [23:0] r_y;
    logic signed [40:0] r_prod;
    logic signed [39:0] r_mix;
    logic [35:0]        r_plo;
    logic signed [55:0] r_tot;
    logic               r_out_valid;
    logic signed [23:0] r_sample_out;

    logic signed [40:0] w_fb_r;
    logic signed [26:0] w_fb_sum;
    logic signed [23:0] w_fb_sat;
    logic [16:0]        w_dry;
    logic signed [41:0] w_dry_p;
    logic signed [41:0] w_mix_sum;
    logic signed [36:0] w_phi;
    logic signed [55:0] w_phi_ext;
    logic signed [55:0] w_tot;
    logic signed [55:0] w_out_r;
    logic signed [23:0] w_out_sat;
    logic               w_out_free;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -32'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    // Feedback: round half up, add input, saturate
    assign w_fb_r   = (r_prod + 41'sd16384) >>> 15;
    assign w_fb_sum = 27'(r_x) + $signed(w_fb_r[26:0]);
    assign w_fb_sat = sat24(32'(w_fb_sum));

    // Mix: dry share is unity minus wet
    assign w_dry     = 17'(Q_ONE) - {1'b0, i_cfg.wet_mix};
    assign w_dry_p   = r_x * $signed({1'b0, w_dry});
    assign w_mix_sum = 42'(r_prod) + w_dry_p;

    // Gain: upper partial product joins the lower one from the cycle before
    assign w_phi     = $signed(r_mix[39:20]) * $signed({1'b0, i_cfg.out_gain});
    assign w_phi_ext = 56'(w_phi);
    assign w_tot     = (w_phi_ext <<< 20) + $signed({20'd0, r_plo});
    assign w_out_r   = (r_tot + 56'sd536870912) >>> 30;
    assign w_out_sat = sat24($signed(w_out_r[31:0]));

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign o_clearing  = (r_state == S_CLR);
    assign o_ram_we    = (r_state == S_CLR) || (r_state == S_WB);
    assign o_ram_waddr = (r_state == S_CLR) ? r_clr_addr : {r_ch, r_wp};
    assign o_ram_wdata = (r_state == S_CLR) ? 24'd0 : w_fb_sat;
    assign o_ram_raddr = {r_ch, r_rp};
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == RAW'(NW - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        {r_ch, r_wp, r_rp, r_x} <= i_q_data;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WT;
                end
                S_WT: begin
                    r_y     <= i_ram_rdata;
                    r_prod  <= $signed(i_ram_rdata) * $signed({1'b0, i_cfg.feedback_gain});
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_prod  <= r_y * $signed({1'b0, i_cfg.wet_mix});
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_mix   <= $signed(w_mix_sum[39:0]);
                    r_state <= S_GN1;
                end
                S_GN1: begin
                    r_plo   <= r_mix[19:0] * i_cfg.out_gain;
                    r_state <= S_GN2;
                end
                S_GN2: begin
                    r_tot   <= w_tot;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        r_sample_out <= w_out_sat;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SFD_ASSERT(a_clear_no_pop, r_state == S_CLR, !o_pop, "item taken during clearing pass")
    `SFD_ASSERT_NEXT(a_pop_reads, o_pop, r_state == S_RD, "popped item did not start a read")
    `SFD_ASSERT_NEXT(a_hold_result, (r_state == S_OUT) && r_out_valid && i_out_stall, (r_state == S_OUT) && $stable(r_sample_out), "stalled result lost")

endmodule

// ===== hw/rtl/stereo_feedback_delay_top.sv =====
// ----------------------------------------------------------------------------
// stereo_feedback_delay_top
// Multi-channel feedback echo with dry/wet mix and output gain.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one item of i_channel and a
// signed 24-bit i_sample_in. Output channel: o_out_valid / i_out_stall carry
// the signed 24-bit o_sample_out, one result per item, in order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 out_gain, 1 feedback_gain, 2 wet_mix, 3 delay_samples); write only
// while no item is in flight. Gains above unity are limited to unity.
// The sequencer in the back part carries out one item at a time: memory read,
// feedback multiply, write-back, mix, two gain partial products, output. A
// two-entry queue lets the front accept items while the back is busy.
// Reset: the delay memory is cleared by a pass over CHANNELS * 2^ceil(log2
// DEPTH) words (262144 by default) and the delay is reduced modulo DEPTH;
// a delay_samples write also starts this reduction. o_in_stall is high
// meanwhile. If the receiver stalls, the result waits in the output register
// and the back part holds the next result until it is taken.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_top #(
    parameter int DEPTH    = 131072,
    parameter int CHANNELS = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_channel,
    input  logic signed [23:0]             i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [23:0]             o_sample_out,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import sfd_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QW  = CW + 2 * AW + 24;
    localparam int RAW = CW + AW;
    localparam int NW  = CHANNELS * (2 ** AW);

    t_cfg           w_cfg;
    logic           w_clearing;
    logic           w_push;
    logic [QW-1:0]  w_push_data;
    logic           w_pop;
    logic [QW-1:0]  w_head;
    logic           w_q_full;
    logic           w_q_empty;
    logic           w_ram_we;
    logic [RAW-1:0] w_ram_waddr;
    logic [23:0]    w_ram_wdata;
    logic [RAW-1:0] w_ram_raddr;
    logic [23:0]    w_ram_rdata;

    sfd_front #(
        .DEPTH    (DEPTH),
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_channel   (i_channel),
        .i_sample_in (i_sample_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .i_clearing  (w_clearing),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    sfd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_full      (w_q_full),
        .o_empty     (w_q_empty)
    );

    sfd_back #(
        .DEPTH    (DEPTH),
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_empty    (w_q_empty),
        .i_q_data     (w_head),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

    sfd_ram #(
        .WIDTH  (SAMPLE_W),
        .DEPTH  (NW),
        .ADDR_W (RAW)
    ) u_delay_mem (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

// ===== verif/tb_stereo_feedback_delay_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_feedback_delay_top
// Self-checking bench for the stereo feedback delay. A scoreboard keeps its own
// copy of both channels' echo memories, write pointers and gain registers, and
// predicts each output sample from every accepted input item. The bench runs
// directed items on the edge cases, then random phases under shifting idle
// patterns. One phase holds the output side off long enough to back up input.
// ----------------------------------------------------------------------------
module tb_stereo_feedback_delay_top;
    import sfd_pkg::*;

    localparam int          DEPTH        = 131072;
    localparam int          CHANNELS     = 2;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_ITEMS  = 140;
    localparam int          DRAIN_CYCLES = 20;
    localparam longint      UNITY        = 32768;

    localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh800000;

    class echo_scoreboard;
        bit signed [SAMPLE_W-1:0]   echo_mem [CHANNELS*DEPTH];
        int unsigned                wr_ptr [CHANNELS];
        bit [GAIN_W-1:0]            out_gain  = RST_OUT_GAIN;
        bit [GAIN_W-1:0]            fb_gain   = RST_FEEDBACK_GAIN;
        bit [GAIN_W-1:0]            wet_gain  = RST_WET_MIX;
        bit [DELAY_W-1:0]           delay_len = RST_DELAY_SAMPLES;
        logic signed [SAMPLE_W-1:0] expected_out_q [$];
        int                         errors;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_OUT_GAIN:      out_gain  = data[GAIN_W-1:0];
                REG_FEEDBACK_GAIN: fb_gain   = data[GAIN_W-1:0];
                REG_WET_MIX:       wet_gain  = data[GAIN_W-1:0];
                REG_DELAY_SAMPLES: delay_len = data[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        function longint limit_gain(bit [GAIN_W-1:0] g);
            return (g > UNITY) ? UNITY : longint'(g);
        endfunction

        // round half up, then drop sh fraction bits
        function longint round_shr(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function logic signed [SAMPLE_W-1:0] sat24(longint v);
            if (v > S24_MAX)
                return S24_MAX;
            if (v < S24_MIN)
                return S24_MIN;
            return v[SAMPLE_W-1:0];
        endfunction

        function void note_sample(logic ch, logic signed [SAMPLE_W-1:0] x);
            int unsigned base;
            int unsigned wp;
            int unsigned rp;
            longint      xs;
            longint      dly;
            longint      mixed;
            base = ch ? DEPTH : 0;
            wp   = wr_ptr[ch];
            // zero delay lands on the word about to be overwritten
            rp   = (wp + DEPTH - (delay_len % DEPTH)) % DEPTH;
            xs   = longint'(x);
            dly  = longint'(echo_mem[base + rp]);
            echo_mem[base + wp] = sat24(xs + round_shr(dly * limit_gain(fb_gain), 15));
            wr_ptr[ch] = (wp + 1) % DEPTH;
            mixed = xs * (UNITY - limit_gain(wet_gain)) + dly * limit_gain(wet_gain);
            expected_out_q.push_back(sat24(round_shr(mixed * limit_gain(out_gain), 30)));
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_out_q.size() == 0) begin
                errors++;
                $display("%0t: sample_out expected none, got %0d", $time, got);
                return;
            end
            want = expected_out_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: sample_out expected %0d, got %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return expected_out_q.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_channel;
    logic signed [SAMPLE_W-1:0]   i_sample_in;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [SAMPLE_W-1:0]   o_sample_out;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    echo_scoreboard sb = new();
    int             send_idle_pct = 11;
    int             recv_idle_pct = 83;
    bit             hold_req      = 1'b0;
    int unsigned    cycle_count   = 0;

    stereo_feedback_delay_top #(
        .DEPTH    (DEPTH),
        .CHANNELS (CHANNELS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_channel    (i_channel),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_sample(i_channel, i_sample_in);
            if (o_out_valid && !i_out_stall)
                sb.check_sample(o_sample_out);
        end
    end

    // output side: random stall, or one long hold-off when asked
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_sample(input logic ch, input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_channel   <= ch;
        i_sample_in <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random(input int n);
        logic signed [SAMPLE_W-1:0] s;
        int                         v;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(7))
                0: s = S24_MAX;
                1: s = S24_MIN;
                2, 3: begin
                    v = int'($urandom_range(511)) - 256;
                    s = v[SAMPLE_W-1:0];
                end
                default: s = SAMPLE_W'($urandom_range(24'hFFFFFF));
            endcase
            send_sample(1'($urandom_range(1)), s);
        end
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] og, input logic [CFG_DATA_W-1:0] fb,
                             input logic [CFG_DATA_W-1:0] wet,
                             input logic [CFG_DATA_W-1:0] dly);
        reg_write(REG_OUT_GAIN, og);
        reg_write(REG_FEEDBACK_GAIN, fb);
        reg_write(REG_WET_MIX, wet);
        reg_write(REG_DELAY_SAMPLES, dly);
        i_cfg_we <= 1'b0;
    endtask

    // drop the last offered item so it is not taken again
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return CFG_DATA_W'(UNITY);
            2:       return '1;
            3, 4:    return CFG_DATA_W'($urandom_range(32768))
                            | (CFG_DATA_W'($urandom_range(1)) << GAIN_W);
            default: return CFG_DATA_W'($urandom_range(17'h1FFFF));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_delay();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(17'h1FFFF));
            default: return CFG_DATA_W'($urandom_range(48, 1));
        endcase
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_channel   = 1'b0;
        i_sample_in = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_OUT_GAIN;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: half wet, unity out, so odd inputs hit the rounding tie
        send_sample(1'b0, 24'sd1);
        send_sample(1'b1, -24'sd1);
        send_sample(1'b0, 24'sd3);
        drain();

        // an out gain over unity clamps; full feedback on a one-sample echo saturates
        configure(17'h1FFFF, 17'd32768, 17'd32768, 17'd1);
        send_sample(1'b0, S24_MAX);
        send_sample(1'b0, S24_MAX);
        send_sample(1'b0, S24_MAX);
        send_sample(1'b0, S24_MIN);
        send_sample(1'b0, S24_MIN);
        send_sample(1'b1, 24'sd1);
        send_sample(1'b1, -24'sd1);
        send_sample(1'b1, 24'sd0);
        send_sample(1'b1, S24_MIN);
        drain();

        // zero delay reads a full memory depth back
        configure(17'd32768, 17'd40000, 17'd16384, 17'd0);
        send_sample(1'b0, 24'sd12345);
        send_sample(1'b1, -24'sd7);
        send_sample(1'b0, S24_MAX);
        send_sample(1'b1, S24_MIN);
        drain();

        configure(17'd0, 17'd0, 17'd0, 17'h1FFFF);
        send_sample(1'b0, S24_MAX);
        send_sample(1'b1, S24_MIN);
        send_sample(1'b0, -24'sd2);
        drain();

        configure(17'd1, 17'd1, 17'd1, 17'd2);
        send_sample(1'b0, S24_MIN);
        send_sample(1'b0, S24_MAX);
        send_sample(1'b0, S24_MIN);

        for (int p = 0; p < 6; p++) begin
            drain();
            send_idle_pct = (p < 2) ? 11 : (p < 4) ? 83 : 0;
            recv_idle_pct = (p < 2) ? 83 : (p < 4) ? 11 : 0;
            case (p)
                0:       configure(17'd32768, 17'd32768, 17'd32768, 17'd3);
                3:       configure(17'hFFFF, 17'd0, 17'd0, 17'h1FFFF);
                default: configure(rand_gain(), rand_gain(), rand_gain(), rand_delay());
            endcase
            // back up the input side while the sender keeps offering items
            if (p == 4)
                hold_req = 1'b1;
            send_random(PHASE_ITEMS);
        end
        i_in_valid <= 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
